// File: hdl/chisq_pkg.sv
// chisq_pkg: constants, state type and register indexes for the chi-square
// uniformity test block
// no dependencies

package chisq_pkg;

  localparam int unsigned COUNT_BITS   = 16;  // observed bin count
  localparam int unsigned FRAC_BITS    = 8;   // fraction bits of the statistic
  localparam int unsigned MAX_BINS     = 32;  // depth of the count store
  localparam int unsigned BIN_IDX_BITS = $clog2(MAX_BINS);
  localparam int unsigned BIN_CNT_BITS = 6;   // bin_count register and bin counters
  localparam int unsigned CRIT_BITS    = 32;
  localparam int unsigned STAT_BITS    = 48;
  localparam int unsigned TOTAL_BITS   = 21;
  localparam int unsigned EXP_BITS     = 16;  // expected count as reported
  localparam int unsigned SQ_BITS      = 2 * TOTAL_BITS;
  localparam int unsigned DIV_STEPS    = STAT_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [STAT_BITS-1:0] STAT_MAX = {STAT_BITS{1'b1}};
  // largest square whose scaled value still fits the statistic
  localparam logic [STAT_BITS-1:0] SQ_LIMIT = STAT_MAX >> FRAC_BITS;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CRITICAL  = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,      // collecting counts
    ST_EXP_DIV,   // total / bins on the shared divider
    ST_EXP_CHK,   // latch expected, test for zero
    ST_RD,        // read one stored count
    ST_SQ,        // squared deviation
    ST_CHK,       // saturate or start the term division
    ST_TERM_DIV,  // scaled square / expected
    ST_ACC,       // saturating accumulate
    ST_OUT        // hand result to the output register
  } chisq_state_e;

endpackage

// File: hdl/chi_square_uniformity_test_top.sv
// chi_square_uniformity_test_top: chi-square goodness-of-fit test of a set of
// bin counts against a uniform distribution
// depends on chisq_pkg

// Bin counts stream in, one per transfer, and are written into a 32-entry
// count store until bin_count of them have arrived (a bin_count of 0 counts as
// 1, above 32 it counts as 32). The transfer carrying the last count starts a
// compute pass that takes no input: one shared restoring divider, one quotient
// bit per cycle, first forms expected = total / bins, then for each stored bin
// the pass reads the store, squares the deviation from expected, divides the
// scaled square by expected (a square past the limit gives a saturated term
// with no division) and adds the term into a saturating accumulator. No new
// count is taken until the result has gone to the output register.
// When expected is zero the bin pass is skipped and the result carries
// zero_expected set with statistic and accepted cleared. The result sits in an
// output register, so the next set may start loading while it waits.
// Configuration must be written while the block is idle only; the block does no check of this.

module chi_square_uniformity_test_top
  import chisq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CRIT_BITS-1:0]    cfg_data_i,
  // input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,   // [15:0] bin_value
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [47:0] statistic, [68:48] total, [84:69] expected, [85] accepted, [87:86] zero
  output logic [87:0]             m_axis_tdata,
  output logic                    m_axis_tuser    // [0] zero_expected
);

  // fsm
  chisq_state_e state_q, state_d;

  // configuration
  logic [BIN_CNT_BITS-1:0] bin_count_q;
  logic [CRIT_BITS-1:0]    critical_q;
  logic [BIN_CNT_BITS-1:0] eff_bins;

  // set state
  logic [TOTAL_BITS-1:0]   total_q;
  logic [BIN_CNT_BITS-1:0] bins_q;
  logic [BIN_CNT_BITS-1:0] bins_inc;
  logic [TOTAL_BITS-1:0]   total_inc;
  logic [COUNT_BITS-1:0]   in_value;
  logic                    in_xfer;
  logic                    set_done;

  // compute pass
  logic [BIN_CNT_BITS-1:0] idx_q;
  logic [TOTAL_BITS-1:0]   expected_q;
  logic                    zero_exp_q;
  logic [SQ_BITS-1:0]      sq_q;
  logic [TOTAL_BITS-1:0]   obs_ext;
  logic [TOTAL_BITS-1:0]   diff;
  logic [STAT_BITS-1:0]    acc_q;
  logic [STAT_BITS:0]      acc_sum;
  logic                    sq_sat;
  logic                    last_bin;

  // count store, one synchronous read port
  logic [COUNT_BITS-1:0]   count_mem [MAX_BINS];
  logic [COUNT_BITS-1:0]   rd_data_q;
  logic                    mem_rd_en;

  // shared restoring divider: quotient shifts into the dividend register
  logic [STAT_BITS-1:0]    div_dq_q;
  logic [TOTAL_BITS-1:0]   div_rem_q;
  logic [TOTAL_BITS-1:0]   div_dvs_q;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;
  logic [TOTAL_BITS:0]     div_trial;
  logic                    div_ge;
  logic [TOTAL_BITS-1:0]   div_rem_nxt;
  logic                    div_step;
  logic                    div_last;

  // output register
  logic                    out_valid_q;
  logic                    out_load;
  logic [STAT_BITS-1:0]    out_stat_q;
  logic [TOTAL_BITS-1:0]   out_total_q;
  logic [EXP_BITS-1:0]     out_exp_q;
  logic                    out_acc_q;
  logic                    out_zero_q;

  // bin count clamped to 1..MAX_BINS
  always_comb begin
    if (bin_count_q == '0) begin
      eff_bins = BIN_CNT_BITS'(1);
    end else if (bin_count_q > BIN_CNT_BITS'(MAX_BINS)) begin
      eff_bins = BIN_CNT_BITS'(MAX_BINS);
    end else begin
      eff_bins = bin_count_q;
    end
  end

  assign in_value  = s_axis_tdata[COUNT_BITS-1:0];
  assign in_xfer   = s_axis_tvalid & s_axis_tready;
  assign bins_inc  = bins_q + BIN_CNT_BITS'(1);
  assign total_inc = total_q + TOTAL_BITS'(in_value);
  assign set_done  = bins_inc >= eff_bins;

  // divider step
  assign div_trial   = {div_rem_q, div_dq_q[STAT_BITS-1]};
  assign div_ge      = div_trial >= {1'b0, div_dvs_q};
  assign div_rem_nxt = div_ge ? TOTAL_BITS'(div_trial - {1'b0, div_dvs_q})
                              : div_trial[TOTAL_BITS-1:0];
  assign div_last    = div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1);

  // deviation, square limit and saturating sum
  assign obs_ext  = TOTAL_BITS'(rd_data_q);
  assign diff     = (obs_ext >= expected_q) ? (obs_ext - expected_q) : (expected_q - obs_ext);
  assign sq_sat   = STAT_BITS'(sq_q) > SQ_LIMIT;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, div_dq_q};
  assign last_bin = (idx_q + BIN_CNT_BITS'(1)) == bins_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:     if (in_xfer && set_done) state_d = ST_EXP_DIV;
      ST_EXP_DIV:  if (div_last) state_d = ST_EXP_CHK;
      ST_EXP_CHK:  state_d = (div_dq_q == '0) ? ST_OUT : ST_RD;
      ST_RD:       state_d = ST_SQ;
      ST_SQ:       state_d = ST_CHK;
      ST_CHK:      state_d = sq_sat ? ST_ACC : ST_TERM_DIV;
      ST_TERM_DIV: if (div_last) state_d = ST_ACC;
      ST_ACC:      state_d = last_bin ? ST_OUT : ST_RD;
      ST_OUT:      if (out_load) state_d = ST_LOAD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_rd_en     = 1'b0;
    div_step      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_LOAD:     s_axis_tready = 1'b1;
      ST_RD:       mem_rd_en = 1'b1;
      ST_EXP_DIV:  div_step = 1'b1;
      ST_TERM_DIV: div_step = 1'b1;
      ST_OUT:      out_load = ~out_valid_q | m_axis_tready;
      default:     ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      bin_count_q <= BIN_CNT_BITS'(1);
      critical_q  <= '0;
      total_q     <= '0;
      bins_q      <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BIN_COUNT: bin_count_q <= cfg_data_i[BIN_CNT_BITS-1:0];
          CFG_CRITICAL:  critical_q  <= cfg_data_i;
          default:       ;
        endcase
      end

      if (in_xfer) begin
        total_q <= total_inc;
        bins_q  <= bins_inc;
      end

      if (state_q == ST_LOAD || state_q == ST_CHK) begin
        div_cnt_q <= '0;
      end else if (div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
      end

      if (state_q == ST_EXP_CHK) begin
        acc_q <= '0;
        idx_q <= '0;
      end

      if (state_q == ST_ACC) begin
        acc_q <= acc_sum[STAT_BITS] ? STAT_MAX : acc_sum[STAT_BITS-1:0];
        idx_q <= idx_q + BIN_CNT_BITS'(1);
      end

      // result handed to the output register: the set restarts empty
      if (out_load) begin
        total_q <= '0;
        bins_q  <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer && set_done) begin
      div_dq_q  <= STAT_BITS'(total_inc);
      div_rem_q <= '0;
      div_dvs_q <= TOTAL_BITS'(eff_bins);
    end else if (state_q == ST_CHK) begin
      // a square past the limit makes a saturated term with no division
      div_dq_q  <= sq_sat ? STAT_MAX : (STAT_BITS'(sq_q) << FRAC_BITS);
      div_rem_q <= '0;
      div_dvs_q <= expected_q;
    end else if (div_step) begin
      div_dq_q  <= {div_dq_q[STAT_BITS-2:0], div_ge};
      div_rem_q <= div_rem_nxt;
    end

    if (state_q == ST_EXP_CHK) begin
      expected_q <= div_dq_q[TOTAL_BITS-1:0];
      zero_exp_q <= div_dq_q == '0;
    end

    if (state_q == ST_SQ) begin
      sq_q <= SQ_BITS'(diff) * SQ_BITS'(diff);
    end

    if (out_load) begin
      out_stat_q  <= acc_q;
      out_total_q <= total_q;
      out_exp_q   <= expected_q[EXP_BITS-1:0];
      out_acc_q   <= ~zero_exp_q & (acc_q < STAT_BITS'(critical_q));
      out_zero_q  <= zero_exp_q;
    end
  end

  // count store
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      count_mem[bins_q[BIN_IDX_BITS-1:0]] <= in_value;
    end
    if (mem_rd_en) begin
      rd_data_q <= count_mem[idx_q[BIN_IDX_BITS-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_acc_q, out_exp_q, out_total_q, out_stat_q};
  assign m_axis_tuser  = out_zero_q;

endmodule
